// ----- src/bfa_pkg.sv -----
`default_nettype none

package bfa_pkg;

	// Table geometry.
	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	// Fixed widths of the result fields.
	localparam int OUT_IDX_W  = 4;
	localparam int OUT_SIZE_W = 16;

	typedef enum logic [1:0] {
		STAT_LOADED        = 2'd0,
		STAT_ALLOCATED     = 2'd1,
		STAT_NOT_ALLOCATED = 2'd2,
		STAT_FULL          = 2'd3
	} status_t;

	// One write to the size table.
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     addr;
		logic [SIZE_BITS-1:0] data;
	} tbl_wr_t;

	// One read of the size table.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	// One finished result.
	typedef struct packed {
		status_t               status;
		logic [OUT_IDX_W-1:0]  block_index;
		logic [OUT_SIZE_W-1:0] remaining_size;
	} result_t;

endpackage

`default_nettype wire

// ----- src/bfa_table.sv -----
`default_nettype none

module bfa_table
	import bfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire tbl_wr_t              wr,
	input  wire tbl_rd_t              rd,
	output logic     [SIZE_BITS-1:0]  rdata
);

	logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port: rdata holds the addressed entry from the cycle after the read.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/bfa_engine.sv -----
`default_nettype none

module bfa_engine
	import bfa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  in_mode,
	input  wire logic [SIZE_BITS-1:0]  in_size,
	output tbl_wr_t                    tbl_wr,
	output tbl_rd_t                    tbl_rd,
	input  wire logic [SIZE_BITS-1:0]  tbl_rdata,
	output logic                       res_valid,
	output result_t                    res,
	input  wire logic                  res_ready
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_COMMIT = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic                 rd_v_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [SIZE_BITS-1:0] req_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	result_t              res_q;

	logic                 accept;
	logic                 full;
	logic                 last_scan;
	logic                 hit;
	logic [SIZE_BITS-1:0] left_size;
	logic [31:0]          load_idx_wide;
	logic [31:0]          best_idx_wide;
	logic [31:0]          load_size_wide;
	logic [31:0]          left_size_wide;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(MAX_BLOCKS));
	assign last_scan = ({1'b0, scan_idx_q} == (count_q - CNT_W'(1)));
	assign left_size = best_size_q - req_q;

	// Result fields at their fixed output widths.
	assign load_idx_wide  = 32'(count_q);
	assign best_idx_wide  = 32'(best_idx_q);
	assign load_size_wide = 32'(in_size);
	assign left_size_wide = 32'(left_size);

	// A fitting block that beats the best one seen so far.
	assign hit = rd_v_s1 && (tbl_rdata >= req_q) && (!found_q || (tbl_rdata < best_size_q));

	// Loads into a table that is not full write on acceptance; an allocation writes its chosen entry at commit.
	always_comb begin
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = best_idx_q;
		tbl_wr.data = left_size;
		if (accept && !in_mode && !full) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.addr = count_q[IDX_W-1:0];
			tbl_wr.data = in_size;
		end else if ((state_q == S_COMMIT) && found_q) begin
			tbl_wr.en = 1'b1;
		end
	end

	// The scan reads one entry per cycle.
	assign tbl_rd.en   = (state_q == S_SCAN);
	assign tbl_rd.addr = scan_idx_q;

	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	// Control sequence and block count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_v_s1    <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN);
			if (hit) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q    <= 1'b0;
						scan_idx_q <= '0;
						if (!in_mode) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_RESULT;
						end else if (count_q == '0) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last_scan) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request size, best candidate and the pending result.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (hit) begin
			best_idx_q  <= rd_idx_s1;
			best_size_q <= tbl_rdata;
		end
		if (accept) begin
			req_q <= in_size;
			if (!in_mode) begin
				if (full) begin
					res_q.status         <= STAT_FULL;
					res_q.block_index    <= '0;
					res_q.remaining_size <= '0;
				end else begin
					res_q.status         <= STAT_LOADED;
					res_q.block_index    <= load_idx_wide[OUT_IDX_W-1:0];
					res_q.remaining_size <= load_size_wide[OUT_SIZE_W-1:0];
				end
			end else begin
				res_q.status         <= STAT_NOT_ALLOCATED;
				res_q.block_index    <= '0;
				res_q.remaining_size <= '0;
			end
		end else if ((state_q == S_COMMIT) && found_q) begin
			res_q.status         <= STAT_ALLOCATED;
			res_q.block_index    <= best_idx_wide[OUT_IDX_W-1:0];
			res_q.remaining_size <= left_size_wide[OUT_SIZE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/best_fit_block_allocator.sv -----
// Best-fit block allocator.
// Requests arrive on the s_ stream: s_tuser is the mode (0 loads a block size into the next
// free slot, 1 allocates) and s_tdata carries the size. Every request gives one result on
// the m_ stream: m_tuser is the status (loaded, allocated, not allocated, table full) and
// m_tdata holds the block index in its low 4 bits and the remaining size above it.
// A load passes from the idle state to the result state. An allocation walks the stored
// entries through the single read port of the size table, one per cycle, then drains
// the last read and commits; an empty table goes straight to the result state. The
// result then moves to the output register and raises m_tvalid; s_tready returns
// as the engine hands the result over. One request is worked on at a time; s_tready is high
// only while the engine is idle.
// The result sits in an output register, so a new request may be accepted while the
// previous result waits for m_tready; if the receiver stalls longer, the finished result
// of the new request is held in the engine and s_tready stays low until it moves on.
// Reset clears the block count and all handshake state; the table contents need no
// clearing, since only loaded slots are ever read.
`default_nettype none

module best_fit_block_allocator
	import bfa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // size[15:0]
	input  wire logic        s_tuser,   // mode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // block_index[3:0], remaining_size[19:4], zero[23:20]
	output logic      [1:0]  m_tuser    // status[1:0]
);

	tbl_wr_t              tbl_wr;
	tbl_rd_t              tbl_rd;
	logic [SIZE_BITS-1:0] tbl_rdata;
	logic                 res_valid;
	logic                 res_ready;
	result_t              res;
	result_t              out_q;
	logic                 out_valid_q;
	logic [31:0]          size_wide;

	assign size_wide = 32'(s_tdata);

	bfa_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.rd    (tbl_rd),
		.rdata (tbl_rdata)
	);

	bfa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_size   (size_wide[SIZE_BITS-1:0]),
		.tbl_wr    (tbl_wr),
		.tbl_rd    (tbl_rd),
		.tbl_rdata (tbl_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {4'b0000, out_q.remaining_size, out_q.block_index};

endmodule

`default_nettype wire

// ----- bench/tb_best_fit_block_allocator.sv -----
`default_nettype none

module tb_best_fit_block_allocator;
	import bfa_pkg::*;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;
	localparam int   QUIET_LIMIT = 2000;
	localparam int   HOLD_CYCLES = 300;
	localparam int   DRAIN_CYCLES = 30;
	localparam int   MAX_REPORTS = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	// Shared between the request driver and the result checker.
	result_t pending_results[$];
	int      errors = 0;
	int      idle_pct = 36;
	logic    pressure_on = 1'b0;

	// Private copy of the free-block table.
	logic [SIZE_BITS-1:0] free_sizes [MAX_BLOCKS];
	int                   loaded_count = 0;

	best_fit_block_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the private table and returns the result it must produce.
	function automatic result_t best_fit_result(input logic mode, input logic [15:0] size);
		result_t r;
		int      best;
		r.status = STAT_NOT_ALLOCATED;
		r.block_index = '0;
		r.remaining_size = '0;
		best = -1;
		if (mode == MODE_LOAD) begin
			if (loaded_count >= MAX_BLOCKS) begin
				r.status = STAT_FULL;
			end else begin
				free_sizes[loaded_count] = size;
				r.status = STAT_LOADED;
				r.block_index = OUT_IDX_W'(loaded_count);
				r.remaining_size = size;
				loaded_count++;
			end
		end else begin
			// Smallest block that still fits; the strict compare keeps the lowest index on a tie.
			for (int j = 0; j < loaded_count; j++) begin
				if (free_sizes[j] >= size && (best < 0 || free_sizes[j] < free_sizes[best]))
					best = j;
			end
			if (best >= 0) begin
				free_sizes[best] = free_sizes[best] - size;
				r.status = STAT_ALLOCATED;
				r.block_index = OUT_IDX_W'(best);
				r.remaining_size = free_sizes[best];
			end
		end
		return r;
	endfunction

	// Request sizes aimed at the blocks that are actually in the table, so that most
	// requests land near a fit boundary instead of missing everything.
	function automatic logic [15:0] pick_request();
		logic [15:0] cur;
		if (loaded_count == 0)
			return 16'($urandom);
		cur = free_sizes[$urandom_range(0, loaded_count - 1)];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom_range(0, cur >> $urandom_range(0, 6)));
			4:          return cur;
			5:          return cur + 16'd1;
			6:          return '0;
			default:    return 16'($urandom);
		endcase
	endfunction

	// Offers one request, with a random gap first, and records its result once accepted.
	task automatic send_request(input logic mode, input logic [15:0] size);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= size;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(best_fit_result(mode, size));
	endtask

	task automatic send_mixed(input int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 5)
				send_request(MODE_LOAD, 16'($urandom));
			else
				send_request(MODE_ALLOC, pick_request());
		end
	endtask

	// Allocation on an empty table, including a zero request.
	task automatic test_empty_table();
		send_request(MODE_ALLOC, 16'd0);
		send_request(MODE_ALLOC, 16'hFFFF);
	endtask

	// Exact fit, equal sizes, a zero-size block and a request that fits nowhere.
	task automatic test_fit_rules();
		send_request(MODE_LOAD, 16'd100);
		send_request(MODE_LOAD, 16'd40);
		send_request(MODE_LOAD, 16'd100);
		send_request(MODE_LOAD, 16'd0);
		send_request(MODE_ALLOC, 16'd100);
		send_request(MODE_ALLOC, 16'd0);
		send_request(MODE_ALLOC, 16'd41);
		send_request(MODE_ALLOC, 16'd60);
	endtask

	// Loads the remaining slots, with the largest size among them, then allocates that size.
	task automatic test_fill_table();
		send_request(MODE_LOAD, 16'hFFFF);
		send_request(MODE_LOAD, 16'h8000);
		send_request(MODE_LOAD, 16'h7FFF);
		send_request(MODE_LOAD, 16'h5555);
		send_request(MODE_LOAD, 16'hAAAA);
		while (loaded_count < MAX_BLOCKS)
			send_request(MODE_LOAD, 16'($urandom));
		send_request(MODE_ALLOC, 16'hFFFF);
	endtask

	// Loads into a full table are dropped.
	task automatic test_table_full();
		send_request(MODE_LOAD, 16'hFFFF);
		send_request(MODE_LOAD, 16'd0);
	endtask

	task automatic test_random_traffic();
		send_mixed(600);
	endtask

	// Both sides run without gaps for a while.
	task automatic test_no_idle();
		idle_pct = 0;
		send_mixed(150);
		idle_pct = 36;
	endtask

	// The receiver stops for a long stretch while requests keep coming.
	task automatic test_backpressure();
		pressure_on <= 1'b1;
		send_mixed(80);
	endtask

	// Result checker and receiver-side ready pattern.
	int   hold_left = 0;
	logic pressure_done = 1'b0;

	always @(posedge clk) begin : receive_side
		result_t exp_r;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with none expected: status %0d index %0d size %0d",
						$time, m_tuser, m_tdata[3:0], m_tdata[19:4]);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tuser != exp_r.status || m_tdata[3:0] != exp_r.block_index ||
						m_tdata[19:4] != exp_r.remaining_size) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"%0t: mismatch: expected status %0d index %0d size %0d,",
							" actual status %0d index %0d size %0d"}, $time,
							exp_r.status, exp_r.block_index, exp_r.remaining_size,
							m_tuser, m_tdata[3:0], m_tdata[19:4]);
				end
			end
		end
		// Ready for the next cycle: a single long hold when asked, else random.
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (pressure_on && !pressure_done) begin
			hold_left <= HOLD_CYCLES;
			pressure_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Watchdog on cycles with no handshake on either side.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_best_fit_block_allocator: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fit_rules();
		test_fill_table();
		test_table_full();
		test_random_traffic();
		test_no_idle();
		test_backpressure();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_best_fit_block_allocator: done, clean");
		else
			$display("tb_best_fit_block_allocator: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/bfa_pkg.sv
src/bfa_table.sv
src/bfa_engine.sv
src/best_fit_block_allocator.sv
bench/tb_best_fit_block_allocator.sv
